### hdl/cfa_pkg.sv
`timescale 1ns / 1ps
package cfa_pkg;

	localparam int NUM_UNITS_DEF = 64;
	localparam int ID_BITS_DEF   = 8;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] POL_BEST  = 2'd0;
	localparam logic [1:0] POL_WORST = 2'd1;
	localparam logic [1:0] POL_FIRST = 2'd2;
	localparam logic [1:0] POL_NONE  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOFIT    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_BAD      = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_CLOSE,
		S_WRITE,
		S_RESP
	} cfa_state_t;

endpackage

### hdl/cfa_cell.sv
`timescale 1ns / 1ps
module cfa_cell #(
	parameter int ID_BITS = cfa_pkg::ID_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift,
	input  logic [ID_BITS-1:0] d,
	output logic [ID_BITS-1:0] q
);
	logic [ID_BITS-1:0] id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q <= '0;
		end else if (shift) begin
			id_q <= d;
		end
	end

	assign q = id_q;

endmodule

### hdl/contiguous_fit_allocator.sv
`timescale 1ns / 1ps
// Contiguous fit allocator over a map of NUM_UNITS units, one owner id per unit.
// Input channel s_axis: one request per transfer (allocate with best, worst or
// first fit, or free by owner id). Output channel m_axis: one result per request
// with status, start unit and unit count.
// The map is a ring of cells that rotates one unit per cycle past a single
// controller. A request takes one rotation to find runs, a closing step, and
// for a successful request a second rotation to write or clear units. A failed
// search skips the second rotation and gives its result after the closing step;
// a bad request goes straight to its result with no rotation. The rotation
// length, one unit per cycle, sets the rate while the receiver keeps up; one
// request is in work at a time. s_axis_tready is high only while the block is
// idle.
// Reset clears the whole map to free at once and drops any pending result.
// When the receiver stalls, the result holds in the output register; the next
// request is taken and processed, and waits for its own result slot.
module contiguous_fit_allocator #(
	parameter int NUM_UNITS = cfa_pkg::NUM_UNITS_DEF,
	parameter int ID_BITS   = cfa_pkg::ID_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// operation[0], fit_policy[2:1], owner_id[10:3], request_size[17:11]
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[1:0], start_unit[7:2], unit_count[14:8]
	output logic [15:0] m_axis_tdata
);
	import cfa_pkg::*;

	localparam int PW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
	localparam int CW = $clog2(NUM_UNITS + 1);
	localparam int SW = (CW > 7) ? CW : 7;

	cfa_state_t state_q, state_d;

	logic [ID_BITS-1:0] ring [NUM_UNITS];
	logic [ID_BITS-1:0] head, tail;
	logic               shift;

	logic               op_q;
	logic [1:0]         pol_q;
	logic [ID_BITS-1:0] id_q;
	logic [6:0]         size_q;
	logic [PW-1:0]      pos_q;
	logic [PW-1:0]      run_start_q, pick_start_q;
	logic [CW-1:0]      run_len_q, pick_len_q;
	logic               found_q;
	logic [1:0]         res_status_q;
	logic [PW-1:0]      res_start_q;
	logic [6:0]         res_count_q;
	logic               out_valid_q;
	logic [1:0]         out_status_q;
	logic [5:0]         out_start_q;
	logic [6:0]         out_count_q;

	logic               in_op;
	logic [1:0]         in_pol;
	logic [7:0]         in_id;
	logic [6:0]         in_size;
	logic               bad_req;
	logic               last_pos;
	logic               close_fit, close_take;
	logic [SW-1:0]      wlen;
	logic [PW-1:0]      diff;
	logic               in_range;

	genvar k;
	generate
		for (k = 0; k < NUM_UNITS; k++) begin : g_cell
			if (k == NUM_UNITS - 1) begin : g_tail
				cfa_cell #(.ID_BITS(ID_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(shift), .d(tail), .q(ring[k])
				);
			end else begin : g_mid
				cfa_cell #(.ID_BITS(ID_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(shift), .d(ring[k+1]), .q(ring[k])
				);
			end
		end
	endgenerate

	assign head = ring[0];

	assign in_op   = s_axis_tdata[0];
	assign in_pol  = s_axis_tdata[2:1];
	assign in_id   = s_axis_tdata[10:3];
	assign in_size = s_axis_tdata[17:11];

	assign bad_req = (in_id == 8'd0) || ((16'(in_id) >> ID_BITS) != 16'd0) ||
		((in_op == OP_ALLOC) && ((in_size == 7'd0) || (in_pol == POL_NONE)));

	assign last_pos = (pos_q == PW'(NUM_UNITS - 1));

	assign close_fit = (run_len_q != '0) && (SW'(run_len_q) >= SW'(size_q));
	always_comb begin
		close_take = 1'b0;
		if (close_fit) begin
			if (!found_q) begin
				close_take = 1'b1;
			end else begin
				case (pol_q)
					POL_BEST:  close_take = run_len_q < pick_len_q;
					POL_WORST: close_take = run_len_q > pick_len_q;
					default:   close_take = 1'b0;
				endcase
			end
		end
	end

	assign wlen     = (op_q == OP_ALLOC) ? SW'(size_q) : SW'(pick_len_q);
	assign diff     = pos_q - pick_start_q;
	assign in_range = (pos_q >= pick_start_q) && (SW'(diff) < wlen);

	always_comb begin
		tail = head;
		if (state_q == S_WRITE && in_range) begin
			tail = (op_q == OP_ALLOC) ? id_q : '0;
		end
	end

	assign shift = (state_q == S_SCAN) || (state_q == S_WRITE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) state_d = bad_req ? S_RESP : S_SCAN;
			end
			S_SCAN: begin
				if (last_pos) state_d = S_CLOSE;
			end
			S_CLOSE: begin
				state_d = (found_q || close_take) ? S_WRITE : S_RESP;
			end
			S_WRITE: begin
				if (last_pos) state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || m_axis_tready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			found_q     <= 1'b0;
			run_len_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESP && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q         <= in_op;
						pol_q        <= in_pol;
						id_q         <= ID_BITS'(in_id);
						size_q       <= in_size;
						pos_q        <= '0;
						found_q      <= 1'b0;
						run_len_q    <= '0;
						pick_len_q   <= '0;
						pick_start_q <= '0;
						res_status_q <= ST_BAD;
						res_start_q  <= '0;
						res_count_q  <= '0;
					end
				end
				S_SCAN: begin
					pos_q <= last_pos ? '0 : pos_q + 1'b1;
					if (op_q == OP_ALLOC) begin
						if (head == '0) begin
							if (run_len_q == '0) run_start_q <= pos_q;
							run_len_q <= run_len_q + 1'b1;
						end else begin
							if (close_take) begin
								found_q      <= 1'b1;
								pick_start_q <= run_start_q;
								pick_len_q   <= run_len_q;
							end
							run_len_q <= '0;
						end
					end else begin
						if (head == id_q) begin
							if (!found_q) begin
								found_q      <= 1'b1;
								pick_start_q <= pos_q;
								pick_len_q   <= CW'(1);
								run_len_q    <= CW'(1);
							end else if (run_len_q != '0) begin
								pick_len_q <= pick_len_q + 1'b1;
							end
						end else begin
							run_len_q <= '0;
						end
					end
				end
				S_CLOSE: begin
					if (op_q == OP_ALLOC && close_take) begin
						found_q      <= 1'b1;
						pick_start_q <= run_start_q;
						pick_len_q   <= run_len_q;
					end
					run_len_q   <= '0;
					res_start_q <= '0;
					res_count_q <= '0;
					if (op_q == OP_ALLOC) begin
						res_status_q <= ST_NOFIT;
					end else begin
						res_status_q <= ST_NOTFOUND;
					end
				end
				S_WRITE: begin
					pos_q <= last_pos ? '0 : pos_q + 1'b1;
					if (last_pos) begin
						res_status_q <= ST_OK;
						res_start_q  <= pick_start_q;
						res_count_q  <= (op_q == OP_ALLOC) ? size_q : 7'(pick_len_q);
					end
				end
				S_RESP: begin
					if (!out_valid_q || m_axis_tready) begin
						out_status_q <= res_status_q;
						out_start_q  <= 6'(res_start_q);
						out_count_q  <= res_count_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_count_q, out_start_q, out_status_q};

`ifndef SYNTHESIS
	a_write_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE) |-> found_q)
		else $error("write pass without a picked run");
	a_close_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLOSE) |=> (state_q == S_WRITE || state_q == S_RESP))
		else $error("bad state after close");
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && $past(state_q) == S_IDLE) |-> (pos_q == '0))
		else $error("scan did not start at unit zero");
	a_write_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WRITE && $past(state_q) == S_CLOSE) |-> (pos_q == '0))
		else $error("write pass misaligned");
`endif

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import cfa_pkg::*;

	localparam int UNITS = 64;

	typedef struct packed {
		logic [6:0] unit_count;
		logic [5:0] start_unit;
		logic [1:0] status;
	} alloc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;

	logic [7:0]    shadow_map [UNITS];
	alloc_result_t pending_results [$];
	int            fail_count = 0;
	bit            send_gaps = 1'b1;
	bit            recv_gaps = 1'b1;
	int            recv_hold = 0;
	int            hold_requests = 0;
	int            holds_done = 0;

	contiguous_fit_allocator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	function automatic alloc_result_t predict_request(logic op, logic [1:0] pol,
			logic [7:0] id, logic [6:0] size);
		alloc_result_t r;
		bit found;
		int pick_start, pick_len, run_start, run_len, i;
		bit take;
		r = '{status: ST_BAD, start_unit: '0, unit_count: '0};
		found = 0;
		pick_start = 0;
		pick_len = 0;
		run_start = 0;
		run_len = 0;
		if (id == 0) return r;
		if (op == OP_ALLOC) begin
			if (size == 0 || pol == POL_NONE) return r;
			for (i = 0; i <= UNITS; i++) begin
				if (i < UNITS && shadow_map[i] == 0) begin
					if (run_len == 0) run_start = i;
					run_len++;
				end else begin
					if (run_len >= size) begin
						if (!found) take = 1;
						else if (pol == POL_BEST) take = run_len < pick_len;
						else if (pol == POL_WORST) take = run_len > pick_len;
						else take = 0;
						if (take) begin
							found = 1;
							pick_start = run_start;
							pick_len = run_len;
						end
					end
					run_len = 0;
				end
			end
			if (!found) begin
				r.status = ST_NOFIT;
				return r;
			end
			for (i = 0; i < size && pick_start + i < UNITS; i++)
				shadow_map[pick_start + i] = id;
			r.status = ST_OK;
			r.start_unit = pick_start[5:0];
			r.unit_count = size;
		end else begin
			i = 0;
			while (i < UNITS && shadow_map[i] != id) i++;
			if (i >= UNITS) begin
				r.status = ST_NOTFOUND;
				return r;
			end
			r.status = ST_OK;
			r.start_unit = i[5:0];
			while (i < UNITS && shadow_map[i] == id) begin
				shadow_map[i] = 0;
				r.unit_count++;
				i++;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	task automatic send_request(logic op, logic [1:0] pol, logic [7:0] id,
			logic [6:0] size);
		int gap;
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, size, id, pol, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(predict_request(op, pol, id, size));
	endtask

	always @(posedge clk) begin
		alloc_result_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[14:0];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", int'(got), 0);
			end else begin
				want = pending_results.pop_front();
				if (got.status != want.status)
					report_mismatch("status", int'(got.status), int'(want.status));
				if (got.start_unit != want.start_unit)
					report_mismatch("start_unit", int'(got.start_unit),
						int'(want.start_unit));
				if (got.unit_count != want.unit_count)
					report_mismatch("unit_count", int'(got.unit_count),
						int'(want.unit_count));
			end
		end
	end

	always @(posedge clk) begin
		if (hold_requests != holds_done) begin
			holds_done <= hold_requests;
			recv_hold <= 600;
			m_axis_tready <= 1'b0;
		end else if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
			recv_hold <= $urandom_range(0, 12);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_request(OP_FREE, POL_BEST, 8'd5, 7'd0);
		send_request(OP_ALLOC, POL_BEST, 8'd0, 7'd4);
		send_request(OP_FREE, POL_BEST, 8'd0, 7'd4);
		send_request(OP_ALLOC, POL_BEST, 8'd1, 7'd0);
		send_request(OP_ALLOC, POL_NONE, 8'd1, 7'd4);
		send_request(OP_ALLOC, POL_FIRST, 8'd1, 7'd65);
		send_request(OP_ALLOC, POL_FIRST, 8'd1, 7'd127);
		send_request(OP_ALLOC, POL_FIRST, 8'd255, 7'd64);
		send_request(OP_ALLOC, POL_FIRST, 8'd2, 7'd1);
		send_request(OP_FREE, POL_NONE, 8'd255, 7'd127);
		send_request(OP_ALLOC, POL_FIRST, 8'd10, 7'd8);
		send_request(OP_ALLOC, POL_FIRST, 8'd11, 7'd4);
		send_request(OP_ALLOC, POL_FIRST, 8'd12, 7'd16);
		send_request(OP_ALLOC, POL_FIRST, 8'd13, 7'd2);
		send_request(OP_FREE, POL_BEST, 8'd11, 7'd0);
		send_request(OP_FREE, POL_BEST, 8'd10, 7'd0);
		send_request(OP_ALLOC, POL_BEST, 8'd20, 7'd3);
		send_request(OP_ALLOC, POL_WORST, 8'd21, 7'd3);
		send_request(OP_ALLOC, POL_FIRST, 8'd20, 7'd5);
		send_request(OP_FREE, POL_FIRST, 8'd20, 7'd0);
		send_request(OP_FREE, POL_FIRST, 8'd20, 7'd0);
		send_request(OP_ALLOC, POL_BEST, 8'd128, 7'd64);
		wait_drained();
	endtask

	task automatic test_backpressure();
		int k;
		hold_requests++;
		for (k = 0; k < 6; k++)
			send_request(OP_ALLOC, POL_FIRST, 8'($urandom_range(1, 255)),
				7'($urandom_range(1, 6)));
		wait_drained();
	endtask

	task automatic test_random(int count);
		int k;
		logic [7:0] id;
		for (k = 0; k < count; k++) begin
			if (k == count - 150) begin
				send_gaps = 1'b0;
				recv_gaps = 1'b0;
			end
			id = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
			if ($urandom_range(0, 29) == 0)
				send_request(1'($urandom), 2'($urandom), id, 7'($urandom));
			else if ($urandom_range(0, 2) == 0)
				send_request(OP_FREE, 2'($urandom), id, 7'($urandom));
			else
				send_request(OP_ALLOC, 2'($urandom_range(0, 2)), id,
					($urandom_range(0, 15) == 0) ? 7'($urandom_range(1, 127))
						: 7'($urandom_range(1, 12)));
		end
	endtask

	initial begin
		foreach (shadow_map[i]) shadow_map[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random(1720);
		wait_drained();
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb_top failed");
		$finish;
	end
endmodule
